// ===== rtl/rast_pkg.sv =====
package rast_pkg;

   localparam int NUM_ELEMENTS_DEFAULT = 1024;

   localparam int INDEX_WIDTH  = 11;
   localparam int AMOUNT_WIDTH = 32;
   localparam int TOTAL_WIDTH  = 64;
   localparam int HALF_WIDTH   = TOTAL_WIDTH / 2;

   // shared multiplier: signed amount (or zero-extended half word) times an index
   localparam int MUL_A_WIDTH = AMOUNT_WIDTH + 1;
   localparam int MUL_B_WIDTH = INDEX_WIDTH + 1;

   localparam logic [1:0] FUNC_ADD  = 2'd0;
   localparam logic [1:0] FUNC_SUM  = 2'd1;
   localparam logic [1:0] FUNC_READ = 2'd2;

   typedef struct packed {
      logic [1:0]                     func;
      logic [INDEX_WIDTH-1:0]         first_index;
      logic [INDEX_WIDTH-1:0]         second_index;
      logic signed [AMOUNT_WIDTH-1:0] amount;
   } req_type;

   typedef struct packed {
      logic signed [TOTAL_WIDTH-1:0] total;
      logic                          range_ok;
   } rsp_type;

endpackage

// ===== rtl/rast_mem.sv =====
module rast_mem #(
   parameter int DEPTH      = rast_pkg::NUM_ELEMENTS_DEFAULT,
   parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  logic                             clock,
   input  logic                             write_enable,
   input  logic [ADDR_WIDTH-1:0]            addr,
   input  logic [rast_pkg::TOTAL_WIDTH-1:0] write_data,
   output logic [rast_pkg::TOTAL_WIDTH-1:0] read_data
);
   import rast_pkg::*;

   logic [TOTAL_WIDTH-1:0] storage_ff [DEPTH];
   logic [TOTAL_WIDTH-1:0] read_data_ff;

   // single port, registered read data (old contents on a write)
   always_ff @(posedge clock) begin
      if (write_enable) begin
         storage_ff[addr] <= write_data;
      end
      read_data_ff <= storage_ff[addr];
   end

   assign read_data = read_data_ff;

endmodule

// ===== rtl/rast_mul.sv =====
module rast_mul (
   input  logic                                    clock,
   input  logic signed [rast_pkg::MUL_A_WIDTH-1:0] mul_a,
   input  logic [rast_pkg::MUL_B_WIDTH-1:0]        mul_b,
   output logic [rast_pkg::TOTAL_WIDTH-1:0]        product
);
   import rast_pkg::*;

   localparam int PROD_WIDTH = MUL_A_WIDTH + MUL_B_WIDTH + 1;

   logic signed [PROD_WIDTH-1:0] full_product;
   logic [TOTAL_WIDTH-1:0]       product_ff;

   assign full_product = PROD_WIDTH'(mul_a) * PROD_WIDTH'($signed({1'b0, mul_b}));

   always_ff @(posedge clock) begin
      product_ff <= {{(TOTAL_WIDTH - PROD_WIDTH){full_product[PROD_WIDTH-1]}}, full_product};
   end

   assign product = product_ff;

endmodule

// ===== rtl/range_add_range_sum_tree.sv =====
// Range add / range sum over NUM_ELEMENTS 64-bit elements, kept as two
// binary indexed trees (slope and offset) in two single-port RAMs.
// Request channel: a beat is taken at a clock edge with start high and busy
// low; busy stays high until the answer has been produced. Result channel:
// rsp_strobe is high for exactly one cycle with rsp_data; the receiver cannot
// stall it, so it must take the beat in that cycle.
// Steps per request:
//   range add    : two update walks, +amt from lo and -amt from hi+1,
//                  one RAM read and one write-back per tree entry touched
//   range sum    : two prefix walks, hi then lo, each followed by the split
//                  64x11 multiply (low half, then high half) and combine
//   element read : one prefix walk over the slope tree
//   rejected     : answered straight from decode
// One request at a time; the RAM read-modify-write per entry sets the rate.
// After reset a clearing pass writes zero to every entry with busy high;
// no result comes out of reset.
module range_add_range_sum_tree #(
   parameter int NUM_ELEMENTS = rast_pkg::NUM_ELEMENTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rast_pkg::req_type req_data,
   output logic              rsp_strobe,
   output rast_pkg::rsp_type rsp_data
);
   import rast_pkg::*;

   localparam int ADDR_WIDTH = $clog2(NUM_ELEMENTS);
   // add walks step k up to at most 2*N before stopping
   localparam int K_WIDTH = $clog2(NUM_ELEMENTS) + 2;
   localparam logic [K_WIDTH-1:0]    K_LIMIT   = K_WIDTH'(NUM_ELEMENTS);
   localparam logic [ADDR_WIDTH-1:0] LAST_ADDR = ADDR_WIDTH'(NUM_ELEMENTS - 1);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_ADD_MUL,
      ST_ADD_SETUP,
      ST_ADD_READ,
      ST_ADD_WRITE,
      ST_PRE_WALK,
      ST_PRE_MUL_LO,
      ST_PRE_MUL_HI,
      ST_PRE_COMBINE,
      ST_PRE_ACC
   } state_type;

   state_type              state_ff, state_in;
   logic [ADDR_WIDTH-1:0]  clear_ff, clear_in;
   req_type                req_ff, req_in;
   logic                   walk_ff, walk_in;      // second walk of an add, second prefix of a sum
   logic [K_WIDTH-1:0]     k_ff, k_in;            // 1-based tree position
   logic [TOTAL_WIDTH-1:0] dslope_ff, dslope_in;
   logic [TOTAL_WIDTH-1:0] doff_ff, doff_in;
   logic [TOTAL_WIDTH-1:0] acc_slope_ff, acc_slope_in;
   logic [TOTAL_WIDTH-1:0] acc_off_ff, acc_off_in;
   logic                   pend_ff, pend_in;      // a prefix read is in flight
   logic [INDEX_WIDTH-1:0] count_ff, count_in;
   logic [TOTAL_WIDTH-1:0] part_ff, part_in;
   logic [TOTAL_WIDTH-1:0] total_ff, total_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   // RAM and multiplier hookup
   logic                   mem_we;
   logic [ADDR_WIDTH-1:0]  mem_addr;
   logic [TOTAL_WIDTH-1:0] slope_wdata, offset_wdata;
   logic [TOTAL_WIDTH-1:0] slope_rdata, offset_rdata;
   logic signed [MUL_A_WIDTH-1:0] mul_a;
   logic [MUL_B_WIDTH-1:0]        mul_b;
   logic [TOTAL_WIDTH-1:0]        product;

   logic [INDEX_WIDTH-1:0] lo_idx, hi_idx;
   logic [MUL_B_WIDTH-1:0] end_idx;
   logic [TOTAL_WIDTH-1:0] amt_ext;
   logic [K_WIDTH-1:0]     k_dec, k_up, k_down;

   assign lo_idx  = req_ff.first_index;
   assign hi_idx  = req_ff.second_index;
   assign end_idx = {1'b0, hi_idx} + MUL_B_WIDTH'(1);
   assign amt_ext = {{(TOTAL_WIDTH - AMOUNT_WIDTH){req_ff.amount[AMOUNT_WIDTH-1]}},
                     req_ff.amount};

   // lowest-set-bit walk steps
   assign k_dec  = k_ff - K_WIDTH'(1);
   assign k_up   = k_ff + (k_ff & (~k_ff + K_WIDTH'(1)));
   assign k_down = k_ff & k_dec;

   assign mem_we       = (state_ff == ST_CLEAR) || (state_ff == ST_ADD_WRITE);
   assign mem_addr     = (state_ff == ST_CLEAR) ? clear_ff : k_dec[ADDR_WIDTH-1:0];
   assign slope_wdata  = (state_ff == ST_CLEAR) ? '0 : slope_rdata + dslope_ff;
   assign offset_wdata = (state_ff == ST_CLEAR) ? '0 : offset_rdata + doff_ff;

   always_comb begin
      mul_a = {req_ff.amount[AMOUNT_WIDTH-1], req_ff.amount};
      mul_b = walk_ff ? end_idx : {1'b0, lo_idx};
      case (state_ff)
         ST_PRE_MUL_LO: begin
            mul_a = {1'b0, acc_slope_ff[HALF_WIDTH-1:0]};
            mul_b = {1'b0, count_ff};
         end
         ST_PRE_MUL_HI: begin
            mul_a = {1'b0, acc_slope_ff[TOTAL_WIDTH-1:HALF_WIDTH]};
            mul_b = {1'b0, count_ff};
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      clear_in      = clear_ff;
      req_in        = req_ff;
      walk_in       = walk_ff;
      k_in          = k_ff;
      dslope_in     = dslope_ff;
      doff_in       = doff_ff;
      acc_slope_in  = acc_slope_ff;
      acc_off_in    = acc_off_ff;
      pend_in       = pend_ff;
      count_in      = count_ff;
      part_in       = part_ff;
      total_in      = total_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         ST_CLEAR: begin
            clear_in = clear_ff + ADDR_WIDTH'(1);
            if (clear_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            // rejected unless a branch below takes it
            rsp_data_in.total    = '0;
            rsp_data_in.range_ok = 1'b0;
            rsp_strobe_in        = 1'b1;
            state_in             = ST_IDLE;
            walk_in              = 1'b0;
            acc_slope_in         = '0;
            acc_off_in           = '0;
            pend_in              = 1'b0;
            case (req_ff.func)
               FUNC_ADD: begin
                  if (lo_idx <= hi_idx && 32'(hi_idx) < 32'(NUM_ELEMENTS)) begin
                     rsp_strobe_in = 1'b0;
                     state_in      = ST_ADD_MUL;
                  end
               end
               FUNC_SUM: begin
                  if (lo_idx <= hi_idx && 32'(hi_idx) <= 32'(NUM_ELEMENTS)) begin
                     rsp_strobe_in = 1'b0;
                     k_in          = K_WIDTH'(hi_idx);
                     count_in      = hi_idx;
                     state_in      = ST_PRE_WALK;
                  end
               end
               FUNC_READ: begin
                  if (32'(lo_idx) < 32'(NUM_ELEMENTS)) begin
                     rsp_strobe_in = 1'b0;
                     k_in          = K_WIDTH'(lo_idx) + K_WIDTH'(1);
                     count_in      = lo_idx;
                     state_in      = ST_PRE_WALK;
                  end
               end
               default: begin
               end
            endcase
         end

         // first walk starts at lo with +amt, second at hi+1 with -amt
         ST_ADD_MUL: begin
            k_in      = walk_ff ? K_WIDTH'(end_idx) + K_WIDTH'(1)
                                : K_WIDTH'(lo_idx) + K_WIDTH'(1);
            dslope_in = walk_ff ? -amt_ext : amt_ext;
            state_in  = ST_ADD_SETUP;
         end

         ST_ADD_SETUP: begin
            doff_in = walk_ff ? -product : product;
            if (k_ff <= K_LIMIT) begin
               state_in = ST_ADD_READ;
            end else if (!walk_ff) begin
               walk_in  = 1'b1;
               state_in = ST_ADD_MUL;
            end else begin
               rsp_data_in.total    = '0;
               rsp_data_in.range_ok = 1'b1;
               rsp_strobe_in        = 1'b1;
               state_in             = ST_IDLE;
            end
         end

         ST_ADD_READ: begin
            state_in = ST_ADD_WRITE;
         end

         ST_ADD_WRITE: begin
            k_in = k_up;
            if (k_up <= K_LIMIT) begin
               state_in = ST_ADD_READ;
            end else if (!walk_ff) begin
               walk_in  = 1'b1;
               state_in = ST_ADD_MUL;
            end else begin
               rsp_data_in.total    = '0;
               rsp_data_in.range_ok = 1'b1;
               rsp_strobe_in        = 1'b1;
               state_in             = ST_IDLE;
            end
         end

         // one read issued per cycle, summed when it returns
         ST_PRE_WALK: begin
            if (pend_ff) begin
               acc_slope_in = acc_slope_ff + slope_rdata;
               acc_off_in   = acc_off_ff + offset_rdata;
            end
            if (k_ff != '0) begin
               k_in    = k_down;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  if (req_ff.func == FUNC_READ) begin
                     rsp_data_in.total    = acc_slope_ff;
                     rsp_data_in.range_ok = 1'b1;
                     rsp_strobe_in        = 1'b1;
                     state_in             = ST_IDLE;
                  end else begin
                     state_in = ST_PRE_MUL_LO;
                  end
               end
            end
         end

         // slope prefix * count, low half then high half
         ST_PRE_MUL_LO: begin
            state_in = ST_PRE_MUL_HI;
         end

         ST_PRE_MUL_HI: begin
            part_in  = product - acc_off_ff;
            state_in = ST_PRE_COMBINE;
         end

         ST_PRE_COMBINE: begin
            part_in  = part_ff + {product[HALF_WIDTH-1:0], {HALF_WIDTH{1'b0}}};
            state_in = ST_PRE_ACC;
         end

         ST_PRE_ACC: begin
            if (!walk_ff) begin
               total_in     = part_ff;
               walk_in      = 1'b1;
               k_in         = K_WIDTH'(lo_idx);
               count_in     = lo_idx;
               acc_slope_in = '0;
               acc_off_in   = '0;
               pend_in      = 1'b0;
               state_in     = ST_PRE_WALK;
            end else begin
               rsp_data_in.total    = total_ff - part_ff;
               rsp_data_in.range_ok = 1'b1;
               rsp_strobe_in        = 1'b1;
               state_in             = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_ff      <= '0;
         walk_ff       <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_ff      <= clear_in;
         walk_ff       <= walk_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff       <= req_in;
      k_ff         <= k_in;
      dslope_ff    <= dslope_in;
      doff_ff      <= doff_in;
      acc_slope_ff <= acc_slope_in;
      acc_off_ff   <= acc_off_in;
      count_ff     <= count_in;
      part_ff      <= part_in;
      total_ff     <= total_in;
      rsp_data_ff  <= rsp_data_in;
   end

   rast_mem #(
      .DEPTH      (NUM_ELEMENTS),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_slope_mem (
      .clock        (clock),
      .write_enable (mem_we),
      .addr         (mem_addr),
      .write_data   (slope_wdata),
      .read_data    (slope_rdata)
   );

   rast_mem #(
      .DEPTH      (NUM_ELEMENTS),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_offset_mem (
      .clock        (clock),
      .write_enable (mem_we),
      .addr         (mem_addr),
      .write_data   (offset_wdata),
      .read_data    (offset_rdata)
   );

   rast_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // a result beat lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request beat taken but block not busy");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.range_ok) |-> (rsp_data.total == '0))
      else $error("rejected request returned nonzero total");

   // update walk only touches entries inside the tree
   a_add_in_tree: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD_READ || state_ff == ST_ADD_WRITE)
         |-> (k_ff != '0 && k_ff <= K_LIMIT))
      else $error("update walk outside the tree");

   a_prefix_in_tree: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PRE_WALK) |-> (k_ff <= K_LIMIT))
      else $error("prefix walk outside the tree");

endmodule

// ===== bench/range_add_range_sum_tree_test.sv =====
module range_add_range_sum_tree_test;

   import rast_pkg::*;

   localparam int NUM = NUM_ELEMENTS_DEFAULT;

   // func code that the block must reject
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   // directed rows either carry a typed-in answer or defer to the predictor
   localparam bit PINNED    = 1'b1;
   localparam bit PREDICTED = 1'b0;

   // leave margin past the largest add walk
   localparam int SETTLE_CYCLES = 80;
   localparam int RANDOM_BEATS  = 1000;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int REPORT_LIMIT  = 10;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // typed-in answer travels with the beat so the monitor sees it at acceptance
   logic    pin_valid;
   rsp_type pin_rsp;

   int      mismatch_count = 0;
   int      cycle_count = 0;
   rsp_type pending_answers[$];

   typedef struct {
      req_type beat;
      bit      pinned;
      rsp_type answer;
   } script_row;

   script_row script[$];

   range_add_range_sum_tree #(
      .NUM_ELEMENTS(NUM)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor: its own copy of both Fenwick trees, cleared like the block.
   // ------------------------------------------------------------------
   logic [63:0] slope_copy [NUM];
   logic [63:0] offset_copy [NUM];

   initial begin
      for (int i = 0; i < NUM; i++) begin
         slope_copy[i]  = '0;
         offset_copy[i] = '0;
      end
   end

   // point update: climb parents by adding the lowest set bit
   function automatic void fenwick_bump(input bit on_offset, input int unsigned pos,
                                        input logic [63:0] delta);
      int unsigned k;
      k = pos + 1;
      while (k >= 1 && k <= NUM) begin
         if (on_offset) begin
            offset_copy[k-1] += delta;
         end else begin
            slope_copy[k-1] += delta;
         end
         k += k & (~k + 1);
      end
   endfunction

   // prefix over the first count positions: strip the lowest set bit each step
   function automatic logic [63:0] fenwick_prefix(input bit on_offset,
                                                  input int unsigned count);
      logic [63:0] acc;
      int unsigned k;
      acc = '0;
      k = (count > NUM) ? NUM : count;
      while (k > 0) begin
         acc += on_offset ? offset_copy[k-1] : slope_copy[k-1];
         k &= k - 1;
      end
      return acc;
   endfunction

   // sum of elements [0, count): slope prefix times count minus offset prefix
   function automatic logic [63:0] head_sum(input int unsigned count);
      return fenwick_prefix(1'b0, count) * 64'(count) - fenwick_prefix(1'b1, count);
   endfunction

   function automatic rsp_type predict_answer(input req_type r);
      rsp_type     ans;
      int unsigned lo;
      int unsigned hi;
      logic [63:0] amt;
      lo  = r.first_index;
      hi  = r.second_index;
      amt = {{32{r.amount[31]}}, r.amount};
      ans = '{total: '0, range_ok: 1'b0};
      case (r.func)
         FUNC_ADD: begin
            if (lo <= hi && hi < NUM) begin
               fenwick_bump(1'b0, lo, amt);
               fenwick_bump(1'b0, hi + 1, 64'd0 - amt);
               fenwick_bump(1'b1, lo, amt * 64'(lo));
               fenwick_bump(1'b1, hi + 1, 64'd0 - amt * 64'(hi + 1));
               ans.range_ok = 1'b1;
            end
         end
         FUNC_SUM: begin
            if (lo <= hi && hi <= NUM) begin
               ans.total    = head_sum(hi) - head_sum(lo);
               ans.range_ok = 1'b1;
            end
         end
         FUNC_READ: begin
            if (lo < NUM) begin
               ans.total    = fenwick_prefix(1'b0, lo + 1);
               ans.range_ok = 1'b1;
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   // ------------------------------------------------------------------
   // Monitor: checks each strobed result against the oldest expectation,
   // then records the answer for a beat accepted at this edge.  All reads
   // here see pre-edge values since every driver uses nonblocking writes.
   // ------------------------------------------------------------------
   task automatic note_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] seen);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("mismatch at cycle %0d: %s expected %h got %h",
                  cycle_count, what, want, seen);
      end
   endtask

   always @(posedge clock) begin : watch_results
      rsp_type want;
      rsp_type predicted;
      if (!reset) begin
         if (rsp_strobe) begin
            if (pending_answers.size() == 0) begin
               note_mismatch("unrequested result, total", '0, rsp_data.total);
            end else begin
               want = pending_answers.pop_front();
               if (rsp_data.total !== want.total) begin
                  note_mismatch("total", want.total, rsp_data.total);
               end
               if (rsp_data.range_ok !== want.range_ok) begin
                  note_mismatch("range_ok", 64'(want.range_ok), 64'(rsp_data.range_ok));
               end
            end
         end
         if (start && !busy) begin
            // predictor always runs so its trees track the block
            predicted = predict_answer(req_data);
            pending_answers.push_back(pin_valid ? pin_rsp : predicted);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("range_add_range_sum_tree_test: errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic add_row(input logic [1:0] func, input int unsigned lo,
                          input int unsigned hi, input logic [31:0] amount,
                          input bit pinned, input logic [63:0] total, input logic ok);
      script_row row;
      row.beat   = '{func: func, first_index: INDEX_WIDTH'(lo),
                     second_index: INDEX_WIDTH'(hi), amount: amount};
      row.pinned = pinned;
      row.answer = '{total: total, range_ok: ok};
      script.push_back(row);
   endtask

   // present one beat, then wait until the block is no longer busy
   task automatic issue(input req_type beat, input bit pinned, input rsp_type answer);
      start     <= 1'b1;
      req_data  <= beat;
      pin_valid <= pinned;
      pin_rsp   <= answer;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // sender holds off until every outstanding answer has come back
   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   function automatic int unsigned edge_index();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 1;
         2: return NUM - 1;
         3: return NUM;
         4: return NUM + 1;
         default: return (1 << INDEX_WIDTH) - 1;
      endcase
   endfunction

   // mostly well-formed ranges with random content, some edges and noise
   function automatic req_type random_beat();
      req_type     r;
      int unsigned pick;
      int unsigned a;
      int unsigned b;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         r.func = FUNC_ADD;
      end else if (pick < 75) begin
         r.func = FUNC_SUM;
      end else if (pick < 95) begin
         r.func = FUNC_READ;
      end else begin
         r.func = FUNC_UNUSED;
      end
      case ($urandom_range(0, 9))
         0: begin
            a = $urandom_range(0, (1 << INDEX_WIDTH) - 1);
            b = $urandom_range(0, (1 << INDEX_WIDTH) - 1);
         end
         1: begin
            a = edge_index();
            b = edge_index();
         end
         default: begin
            a = $urandom_range(0, NUM);
            b = $urandom_range(0, NUM);
            if (a > b) begin
               {a, b} = {b, a};
            end
            if (r.func == FUNC_ADD && b == NUM) b = NUM - 1;
            if (r.func == FUNC_READ && a == NUM) a = $urandom_range(0, NUM - 1);
         end
      endcase
      r.first_index  = INDEX_WIDTH'(a);
      r.second_index = INDEX_WIDTH'(b);
      case ($urandom_range(0, 7))
         0, 1: r.amount = $urandom;
         2: begin
            case ($urandom_range(0, 3))
               0: r.amount = 32'h8000_0000;
               1: r.amount = 32'h7fff_ffff;
               2: r.amount = 32'hffff_ffff;
               default: r.amount = '0;
            endcase
         end
         default: r.amount = 32'($urandom_range(0, 2000)) - 32'd1000;
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : run_test
      req_type beat;
      int      sent;
      int      burst;
      bit      paused_mid;
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      pin_valid = 1'b0;
      pin_rsp   = '0;

      // directed rows; pinned answers follow from the cleared trees and the
      // whole-array add of one
      add_row(FUNC_READ, 0, 0, 0, PINNED, 0, 1'b1);
      add_row(FUNC_SUM, 0, NUM, 0, PINNED, 0, 1'b1);
      add_row(FUNC_READ, NUM - 1, 0, 0, PINNED, 0, 1'b1);
      add_row(FUNC_READ, NUM, 0, 0, PINNED, 0, 1'b0);             // read past the end
      add_row(FUNC_READ, 2047, 2047, 32'h7fff_ffff, PINNED, 0, 1'b0);
      add_row(FUNC_ADD, 0, NUM - 1, 1, PINNED, 0, 1'b1);
      add_row(FUNC_SUM, 0, NUM, 0, PINNED, NUM, 1'b1);
      add_row(FUNC_ADD, 5, 4, 9, PINNED, 0, 1'b0);                // reversed add range
      add_row(FUNC_ADD, 0, NUM, 5, PINNED, 0, 1'b0);              // add end past array
      add_row(FUNC_ADD, 2047, 2047, 32'hffff_ffff, PINNED, 0, 1'b0);
      add_row(FUNC_ADD, NUM - 1, NUM - 1, 32'h8000_0000, PINNED, 0, 1'b1); // closing walk off tree
      add_row(FUNC_READ, NUM - 1, 0, 0, PREDICTED, 0, 1'b0);
      add_row(FUNC_ADD, 0, 0, 32'h7fff_ffff, PINNED, 0, 1'b1);
      add_row(FUNC_SUM, 7, 7, 0, PINNED, 0, 1'b1);                // empty interval
      add_row(FUNC_SUM, 8, 7, 0, PINNED, 0, 1'b0);
      add_row(FUNC_SUM, 0, NUM + 1, 0, PINNED, 0, 1'b0);
      add_row(FUNC_SUM, 2047, 2047, 0, PINNED, 0, 1'b0);
      add_row(FUNC_UNUSED, 0, NUM - 1, 32'h1234_5678, PINNED, 0, 1'b0);
      add_row(FUNC_UNUSED, 2047, 2047, 32'hffff_ffff, PINNED, 0, 1'b0);
      add_row(FUNC_SUM, 0, NUM, 0, PREDICTED, 0, 1'b0);
      add_row(FUNC_SUM, 1, NUM - 1, 32'hffff_ffff, PREDICTED, 0, 1'b0); // amount ignored
      add_row(FUNC_READ, 0, 0, 32'h8000_0000, PREDICTED, 0, 1'b0);
      add_row(FUNC_ADD, 'h155, 'h2aa, 32'haaaa_aaaa, PREDICTED, 0, 1'b0);
      add_row(FUNC_SUM, 'h2aa, 'h400, 32'h5555_5555, PREDICTED, 0, 1'b0);
      add_row(FUNC_READ, 'h2aa, 'h555, 0, PREDICTED, 0, 1'b0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed beats back to back; the block's clearing pass holds busy
      foreach (script[i]) begin
         issue(script[i].beat, script[i].pinned, script[i].answer);
      end
      drain();

      // random beats in bursts with random gaps; some bursts run with no gap
      sent = 0;
      paused_mid = 1'b0;
      while (sent < RANDOM_BEATS) begin
         burst = $urandom_range(1, 16);
         for (int j = 0; j < burst && sent < RANDOM_BEATS; j++) begin
            beat = random_beat();
            issue(beat, PREDICTED, '0);
            sent++;
         end
         if (!paused_mid && sent >= RANDOM_BEATS / 2) begin
            paused_mid = 1'b1;
            drain();
         end else if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge clock);
         end
      end

      drain();
      // catch any stray strobe after the last answer
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("range_add_range_sum_tree_test: clean");
      end else begin
         $display("range_add_range_sum_tree_test: errors");
      end
      $finish;
   end

endmodule
